[hdl/assert_macros.svh]
// assertion macros used by the frame receiver top level
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ILFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("frame receiver assertion failed");

// next-cycle implication, disabled during reset
`define ILFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("frame receiver assertion failed");

`endif

[hdl/ilfr_pkg.sv]
// types, codes and defaults for the idle-line frame receiver
// no dependencies
package ilfr_pkg;

	localparam int FRAME_BYTES_DEF = 10;
	localparam int LEN_W = 4;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_IDLE = 2'd1;
	localparam logic [1:0] KIND_TAKE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic [7:0] room;
	} item_t;

	typedef struct packed {
		logic             taken;
		logic [7:0]       frame_byte;
		logic [LEN_W-1:0] frame_length;
		logic             last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic wr_byte;
		logic close;
		logic refuse;
		logic rd_start;
		logic read;
		logic emit;
		logic clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic can_store;
		logic can_close;
		logic can_take;
		logic pending;
		logic empty;
		logic rd_last;
	} dp_status_t;

endpackage

[hdl/ilfr_ctrl.sv]
// controller state machine for the idle-line frame receiver
// depends on ilfr_pkg
module ilfr_ctrl
	import ilfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  dp_status_t status,
	output logic       busy,
	output ctl_cmd_t   cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					case (kind)
						KIND_BYTE: begin
							cmd.wr_byte = status.can_store;
						end
						KIND_IDLE: begin
							cmd.close = status.can_close;
						end
						KIND_TAKE: begin
							if (status.can_take) begin
								cmd.rd_start = 1'b1;
								state_d      = ST_FETCH;
							end else begin
								cmd.refuse = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FETCH: begin
				cmd.read = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.rd_last) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.read = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/ilfr_dp.sv]
// datapath: frame store, byte count, pending flag, read pointer, result register
// depends on ilfr_pkg
module ilfr_dp
	import ilfr_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	output logic       strobe,
	output result_t    result
);

	localparam int CNT_W = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

	logic [7:0]       store_q [FRAME_BYTES];
	logic [7:0]       rdata_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_q;
	logic             pending_q;
	logic             valid_q;
	result_t          res_q;
	logic [EXT_W-1:0] len_ext;
	logic             room_ok;

	assign len_ext = EXT_W'(count_q);
	assign room_ok = ({1'b0, item.room} >= 9'(FRAME_BYTES));

	assign status.can_store = !pending_q && (count_q < CNT_W'(FRAME_BYTES));
	assign status.can_close = !pending_q && (count_q != '0);
	assign status.can_take  = room_ok && pending_q && (count_q != '0);
	assign status.pending   = pending_q;
	assign status.empty     = (count_q == '0);
	assign status.rd_last   = (rd_q == count_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			store_q[count_q[IDX_W-1:0]] <= item.rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rdata_q <= store_q[rd_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= 1'b0;
			rd_q      <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= cmd.refuse || cmd.emit;
			if (cmd.wr_byte) begin
				count_q <= count_q + 1'b1;
				if (count_q == CNT_W'(FRAME_BYTES - 1)) begin
					pending_q <= 1'b1;
				end
			end
			if (cmd.close) begin
				pending_q <= 1'b1;
			end
			if (cmd.clear) begin
				count_q   <= '0;
				pending_q <= 1'b0;
			end
			if (cmd.rd_start) begin
				rd_q <= '0;
			end else if (cmd.read) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.refuse) begin
			res_q <= '{taken: 1'b0, frame_byte: 8'd0, frame_length: '0, last: 1'b1};
		end else if (cmd.emit) begin
			res_q.taken        <= 1'b1;
			res_q.frame_byte   <= rdata_q;
			res_q.frame_length <= len_ext[LEN_W-1:0];
			res_q.last         <= status.rd_last;
		end
	end

	assign strobe = valid_q;
	assign result = res_q;

endmodule

[hdl/idle_line_frame_receiver_top.sv]
// top level of the idle-line frame receiver: controller plus datapath
// depends on ilfr_pkg, ilfr_ctrl, ilfr_dp and assert_macros.svh
//
// channel   direction  handshake             payload
// item      in         start high, busy low  item_t   (kind, rx_byte, room)
// result    out        strobe, one cycle     result_t (taken, frame_byte, frame_length, last)
//
// a byte or idle event is accepted while busy stays low
// a refused take gives its single result the cycle after acceptance
// a granted take holds busy while the frame is read out (one store read per byte,
// read data registered); results follow one per cycle, the last as busy falls
// reset clears count, pending flag and controller; the frame store is not cleared
// the receiver cannot stall results
`include "assert_macros.svh"

module idle_line_frame_receiver_top
	import ilfr_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	ilfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	ilfr_dp #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.strobe (strobe),
		.result (result)
	);

	`ILFR_ASSERT_NOW(a_refusal_is_last, clk, arst_n, strobe && !result.taken, result.last)
	`ILFR_ASSERT_NOW(a_take_ends_with_last, clk, arst_n, $fell(busy), strobe && result.taken && result.last)
	`ILFR_ASSERT_NEXT(a_clear_empties, clk, arst_n, cmd.clear, status.empty && !status.pending)

endmodule

[tb/sv/idle_line_frame_receiver_top_test.sv]
// self-checking bench for idle_line_frame_receiver_top: directed and random line events,
// expected frames from an in-bench model of the frame store, strobed results checked in order
// depends on ilfr_pkg and the receiver rtl
module idle_line_frame_receiver_top_test
	import ilfr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 320;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		item_t ev;
		logic drain;
	} line_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic strobe;
	result_t result;

	line_event_t line_events_q[$];
	line_event_t head_ev;
	result_t frame_results_q[$];
	result_t want;

	logic [7:0] frame_copy [FRAME_BYTES];
	int unsigned stored_n = 0;
	logic frame_ready = 1'b0;
	int unsigned sent_n = 0;
	int unsigned mismatch_cnt = 0;

	idle_line_frame_receiver_top #(.FRAME_BYTES(FRAME_BYTES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void queue_event(input logic [1:0] k, input logic [7:0] b,
		input logic [7:0] r);
		line_event_t e;
		e.ev.kind = k;
		e.ev.rx_byte = b;
		e.ev.room = r;
		e.drain = 1'b0;
		line_events_q.push_back(e);
	endfunction

	// expected results of one accepted item, tracking the frame store
	function automatic void frame_rx_apply(input item_t ev);
		result_t r;
		int unsigned i;
		case (ev.kind)
			KIND_BYTE: begin
				if (!frame_ready && stored_n < FRAME_BYTES) begin
					frame_copy[stored_n] = ev.rx_byte;
					stored_n++;
					if (stored_n >= FRAME_BYTES)
						frame_ready = 1'b1;
				end
			end
			KIND_IDLE: begin
				if (!frame_ready && stored_n != 0)
					frame_ready = 1'b1;
			end
			KIND_TAKE: begin
				if (ev.room < FRAME_BYTES || !frame_ready || stored_n == 0) begin
					r = '0;
					r.last = 1'b1;
					frame_results_q.push_back(r);
				end else begin
					for (i = 0; i < stored_n; i++) begin
						r.taken = 1'b1;
						r.frame_byte = frame_copy[i];
						r.frame_length = LEN_W'(stored_n);
						r.last = (i + 1 == stored_n);
						frame_results_q.push_back(r);
					end
					stored_n = 0;
					frame_ready = 1'b0;
				end
			end
			default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy) begin
				frame_rx_apply(item);
				sent_n++;
			end
			if (!start || !busy) begin
				if (line_events_q.size() == 0
					|| (($urandom_range(0, 99) < 27) && !(sent_n >= 120 && sent_n < 220))
					|| (line_events_q[0].drain && (frame_results_q.size() != 0 || busy))) begin
					start <= 1'b0;
				end else begin
					head_ev = line_events_q.pop_front();
					start <= 1'b1;
					item <= head_ev.ev;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (frame_results_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: taken %0b byte %02h len %0d last %0b",
						result.taken, result.frame_byte, result.frame_length, result.last);
			end else begin
				want = frame_results_q.pop_front();
				if (result.taken !== want.taken || result.frame_byte !== want.frame_byte
					|| result.frame_length !== want.frame_length
					|| result.last !== want.last) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("result mismatch: expected %0b/%02h/%0d/%0b got %0b/%02h/%0d/%0b",
							want.taken, want.frame_byte, want.frame_length, want.last,
							result.taken, result.frame_byte, result.frame_length, result.last);
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("idle_line_frame_receiver_top regression: fail");
		$finish;
	end

	initial begin
		int unsigned useful_n;
		int unsigned n;
		int unsigned k;
		// directed: empty store, unused kind, short frame, refusals, full frame, unclosed frame
		queue_event(KIND_TAKE, 8'h00, 8'hFF);
		queue_event(KIND_IDLE, 8'h5A, 8'h00);
		queue_event(KIND_UNUSED, 8'hFF, 8'hFF);
		queue_event(KIND_BYTE, 8'h00, 8'h00);
		queue_event(KIND_BYTE, 8'hFF, 8'hFF);
		queue_event(KIND_IDLE, 8'h00, 8'h00);
		queue_event(KIND_BYTE, 8'hAA, 8'h00);
		queue_event(KIND_IDLE, 8'hFF, 8'hFF);
		queue_event(KIND_TAKE, 8'h00, 8'(FRAME_BYTES - 1));
		queue_event(KIND_TAKE, 8'hFF, 8'h00);
		queue_event(KIND_TAKE, 8'h00, 8'(FRAME_BYTES));
		for (k = 0; k < FRAME_BYTES; k++)
			queue_event(KIND_BYTE, 8'($urandom), 8'($urandom));
		queue_event(KIND_BYTE, 8'h55, 8'h00);
		queue_event(KIND_TAKE, 8'h00, 8'hFF);
		queue_event(KIND_BYTE, 8'h80, 8'h00);
		queue_event(KIND_TAKE, 8'h00, 8'hFF);
		queue_event(KIND_IDLE, 8'h00, 8'h00);
		queue_event(KIND_TAKE, 8'h00, 8'(FRAME_BYTES));

		// random: mostly whole frames, some stray events
		useful_n = 0;
		while (useful_n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 80) begin
				n = ($urandom_range(0, 3) == 0) ? FRAME_BYTES : $urandom_range(1, FRAME_BYTES);
				for (k = 0; k < n; k++)
					queue_event(KIND_BYTE, 8'($urandom), 8'($urandom));
				if (n < FRAME_BYTES || $urandom_range(0, 3) == 0)
					queue_event(KIND_IDLE, 8'($urandom), 8'($urandom));
				if ($urandom_range(0, 4) == 0)
					queue_event(KIND_BYTE, 8'($urandom), 8'($urandom));
				if ($urandom_range(0, 4) == 0)
					queue_event(KIND_TAKE, 8'($urandom),
						8'($urandom_range(0, FRAME_BYTES - 1)));
				queue_event(KIND_TAKE, 8'($urandom), 8'($urandom_range(FRAME_BYTES, 255)));
				useful_n += n + 2;
			end else begin
				queue_event(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
			end
		end
		line_events_q[line_events_q.size() / 2].drain = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (line_events_q.size() != 0 || start) @(posedge clk);
		while (frame_results_q.size() != 0) @(posedge clk);
		repeat (FRAME_BYTES + 8) @(posedge clk);
		if (mismatch_cnt == 0 && frame_results_q.size() == 0)
			$display("idle_line_frame_receiver_top regression: pass");
		else
			$display("idle_line_frame_receiver_top regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/ilfr_pkg.sv
hdl/ilfr_ctrl.sv
hdl/ilfr_dp.sv
hdl/idle_line_frame_receiver_top.sv
tb/sv/idle_line_frame_receiver_top_test.sv
